### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Types and codes of the display command parser.
// ----------------------------------------------------------------------------
package dcp_pkg;

   // Opcodes
   localparam logic [7:0] OP_CTRL     = 8'h00;
   localparam logic [7:0] OP_BUTTONS  = 8'h01;
   localparam logic [7:0] OP_SKIP_A   = 8'h02;
   localparam logic [7:0] OP_SKIP_B   = 8'h03;
   localparam logic [7:0] OP_TEXT     = 8'h10;
   localparam logic [7:0] OP_PTEXT    = 8'h11;
   localparam logic [7:0] OP_GREEN    = 8'h20;
   localparam logic [7:0] OP_RED      = 8'h21;
   localparam logic [7:0] OP_YELLOW   = 8'h22;
   localparam logic [7:0] OP_DATE     = 8'hF8;
   localparam logic [7:0] OP_TIME     = 8'hF9;
   localparam logic [7:0] OP_VERSION  = 8'hFA;

   // Action codes
   localparam logic [3:0] ACT_NONE    = 4'd0;
   localparam logic [3:0] ACT_BUTTONS = 4'd1;
   localparam logic [3:0] ACT_ZERO    = 4'd2;
   localparam logic [3:0] ACT_GREEN   = 4'd3;
   localparam logic [3:0] ACT_RED     = 4'd4;
   localparam logic [3:0] ACT_YELLOW  = 4'd5;
   localparam logic [3:0] ACT_TEXT    = 4'd6;
   localparam logic [3:0] ACT_DATE    = 4'd7;
   localparam logic [3:0] ACT_TIME    = 4'd8;
   localparam logic [3:0] ACT_VERSION = 4'd9;

   typedef enum logic [11:0] {
      M_CMD       = 12'b0000_0000_0001,
      M_CTRL      = 12'b0000_0000_0010,
      M_SWALLOW   = 12'b0000_0000_0100,
      M_TEXT_LEN  = 12'b0000_0000_1000,
      M_PTEXT_LEN = 12'b0000_0001_0000,
      M_PTEXT_OFF = 12'b0000_0010_0000,
      M_CHARS     = 12'b0000_0100_0000,
      M_G_LED     = 12'b0000_1000_0000,
      M_R_LED     = 12'b0001_0000_0000,
      M_Y_LED     = 12'b0010_0000_0000,
      M_RD_ISSUE  = 12'b0100_0000_0000,
      M_RD_LOAD   = 12'b1000_0000_0000
   } mode_type;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] tx_byte;
      logic [7:0] led_value;
      logic [7:0] text_char;
      logic [3:0] text_index;
      logic [4:0] text_length;
      logic [7:0] text_offset;
      logic       last;
   } rsp_payload_type;

   // Single, final result of a non-text command.
   function automatic rsp_payload_type simple_rsp(logic [3:0] act, logic [7:0] tx,
                                                  logic [7:0] led);
      rsp_payload_type r;
      r           = '0;
      r.action    = act;
      r.tx_byte   = tx;
      r.led_value = led;
      r.last      = 1'b1;
      return r;
   endfunction

endpackage

### design/dcp_intf.sv
// ----------------------------------------------------------------------------
// dcp_intf
// Request and response channel interfaces of the display command parser.
// ----------------------------------------------------------------------------
interface dcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [7:0] button_state;

   modport source (output valid, output rx_byte, output button_state, input ready);
   modport sink   (input valid, input rx_byte, input button_state, output ready);
endinterface

interface dcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] tx_byte;
   logic [7:0] led_value;
   logic [7:0] text_char;
   logic [3:0] text_index;
   logic [4:0] text_length;
   logic [7:0] text_offset;
   logic       last;

   modport source (output valid, output action, output tx_byte, output led_value,
                   output text_char, output text_index, output text_length,
                   output text_offset, output last, input ready);
   modport sink   (input valid, input action, input tx_byte, input led_value,
                   input text_char, input text_index, input text_length,
                   input text_offset, input last, output ready);
endinterface

### design/dcp_ram.sv
// ----------------------------------------------------------------------------
// dcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/display_command_parser.sv
// ----------------------------------------------------------------------------
// display_command_parser
// Parses the slave-bus command byte stream and emits display actions.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_ch    in         rx_byte, button_state
//  rsp_ch    out        action, tx_byte, led_value, text_char, text_index,
//                       text_length, text_offset, last
//
//  A request is taken whenever the output register is free or being drained
//  and no readout runs. A byte that completes a non-empty text run starts a
//  readout from the text buffer memory, a read issue and a load step per
//  character, with requests held off; an empty run yields one marker result.
//  Reset (synchronous) returns to command wait and empties the output; the
//  buffer memory is not cleared. A stalled response holds everything.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module display_command_parser import dcp_pkg::*; #(
   parameter int BUF_DEPTH = 16
) (
   input logic  clock,
   input logic  reset,
   dcp_req_if.sink   req_ch,
   dcp_rsp_if.source rsp_ch
);

   localparam int LW = $clog2(BUF_DEPTH + 1);
   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   mode_type        mode_ff, mode_in;
   logic [LW-1:0]   msg_len_ff, msg_len_in;
   logic [7:0]      msg_off_ff, msg_off_in;
   logic [LW-1:0]   char_cnt_ff, char_cnt_in;
   logic [AW-1:0]   rd_idx_ff, rd_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            req_ready;
   logic            accept;
   logic [LW-1:0]   cnt_next;
   logic [LW-1:0]   len_clamped;
   logic            run_end;
   logic            wr_en;
   logic            rd_en;
   logic [7:0]      rd_data;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready   = out_free && (mode_ff != M_RD_ISSUE) && (mode_ff != M_RD_LOAD);
   assign accept      = req_ch.valid && req_ready;
   assign cnt_next    = char_cnt_ff + LW'(1);
   assign len_clamped = (req_ch.rx_byte > 8'(BUF_DEPTH)) ? LW'(BUF_DEPTH)
                                                         : LW'(req_ch.rx_byte);
   assign run_end     = (LW'(rd_idx_ff) == msg_len_ff - LW'(1));

   always_comb begin
      mode_in      = mode_ff;
      msg_len_in   = msg_len_ff;
      msg_off_in   = msg_off_ff;
      char_cnt_in  = char_cnt_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (mode_ff)
         M_CMD: begin
            if (accept) begin
               unique case (req_ch.rx_byte)
                  OP_CTRL:    mode_in = M_CTRL;
                  OP_BUTTONS: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = simple_rsp(ACT_BUTTONS, req_ch.button_state, 8'h00);
                  end
                  OP_SKIP_A,
                  OP_SKIP_B:  mode_in = M_SWALLOW;
                  OP_TEXT:    mode_in = M_TEXT_LEN;
                  OP_PTEXT:   mode_in = M_PTEXT_LEN;
                  OP_GREEN:   mode_in = M_G_LED;
                  OP_RED:     mode_in = M_R_LED;
                  OP_YELLOW:  mode_in = M_Y_LED;
                  OP_DATE: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = simple_rsp(ACT_DATE, 8'h00, 8'h00);
                  end
                  OP_TIME: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = simple_rsp(ACT_TIME, 8'h00, 8'h00);
                  end
                  OP_VERSION: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = simple_rsp(ACT_VERSION, 8'h00, 8'h00);
                  end
                  default: ;  // drop unknown opcodes
               endcase
            end
         end
         M_CTRL: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = simple_rsp(ACT_ZERO, 8'h00, 8'h00);
               mode_in      = M_CMD;
            end
         end
         M_SWALLOW: begin
            if (accept) begin
               mode_in = M_CMD;
            end
         end
         M_TEXT_LEN: begin
            if (accept) begin
               msg_len_in  = len_clamped;
               msg_off_in  = 8'h00;
               char_cnt_in = '0;
               mode_in     = M_CHARS;
            end
         end
         M_PTEXT_LEN: begin
            if (accept) begin
               msg_len_in = len_clamped;
               mode_in    = M_PTEXT_OFF;
            end
         end
         M_PTEXT_OFF: begin
            if (accept) begin
               msg_off_in  = req_ch.rx_byte;
               char_cnt_in = '0;
               mode_in     = M_CHARS;
            end
         end
         M_CHARS: begin
            if (accept) begin
               wr_en       = 1'b1;
               char_cnt_in = cnt_next;
               if (cnt_next >= msg_len_ff) begin
                  char_cnt_in = '0;
                  if (msg_len_ff == '0) begin
                     // empty commit: one marker result
                     rsp_valid_in             = 1'b1;
                     rsp_data_in              = '0;
                     rsp_data_in.action       = ACT_TEXT;
                     rsp_data_in.text_offset  = msg_off_ff;
                     rsp_data_in.last         = 1'b1;
                     mode_in                  = M_CMD;
                  end else begin
                     rd_idx_in = '0;
                     mode_in   = M_RD_ISSUE;
                  end
               end
            end
         end
         M_G_LED, M_R_LED, M_Y_LED: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               priority if (mode_ff == M_G_LED) begin
                  rsp_data_in = simple_rsp(ACT_GREEN, 8'h00, req_ch.rx_byte);
               end else if (mode_ff == M_R_LED) begin
                  rsp_data_in = simple_rsp(ACT_RED, 8'h00, req_ch.rx_byte);
               end else begin
                  rsp_data_in = simple_rsp(ACT_YELLOW, 8'h00, req_ch.rx_byte);
               end
               mode_in = M_CMD;
            end
         end
         M_RD_ISSUE: begin
            // issue the read only once the output slot frees up
            if (out_free) begin
               rd_en   = 1'b1;
               mode_in = M_RD_LOAD;
            end
         end
         M_RD_LOAD: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in.action      = ACT_TEXT;
            rsp_data_in.text_char   = rd_data;
            rsp_data_in.text_index  = 4'(rd_idx_ff);
            rsp_data_in.text_length = 5'(msg_len_ff);
            rsp_data_in.text_offset = msg_off_ff;
            rsp_data_in.last        = run_end;
            if (run_end) begin
               mode_in = M_CMD;
            end else begin
               rd_idx_in = rd_idx_ff + AW'(1);
               mode_in   = M_RD_ISSUE;
            end
         end
         default: mode_in = M_CMD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_CMD;
         msg_len_ff   <= '0;
         msg_off_ff   <= '0;
         char_cnt_ff  <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         msg_len_ff   <= msg_len_in;
         msg_off_ff   <= msg_off_in;
         char_cnt_ff  <= char_cnt_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   dcp_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_text_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (char_cnt_ff[AW-1:0]),
      .wr_data (req_ch.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action      = rsp_data_ff.action;
   assign rsp_ch.tx_byte     = rsp_data_ff.tx_byte;
   assign rsp_ch.led_value   = rsp_data_ff.led_value;
   assign rsp_ch.text_char   = rsp_data_ff.text_char;
   assign rsp_ch.text_index  = rsp_data_ff.text_index;
   assign rsp_ch.text_length = rsp_data_ff.text_length;
   assign rsp_ch.text_offset = rsp_data_ff.text_offset;
   assign rsp_ch.last        = rsp_data_ff.last;

   `ASSERT_IMPL(a_no_req_in_readout,
      req_ch.valid && req_ch.ready, (mode_ff != M_RD_ISSUE) && (mode_ff != M_RD_LOAD),
      "request taken during text readout")
   `ASSERT_IMPL(a_load_slot_empty, mode_ff == M_RD_LOAD, !rsp_valid_ff,
      "readout load with output register occupied")
   `ASSERT_IMPL(a_rd_idx_in_run, mode_ff == M_RD_ISSUE, LW'(rd_idx_ff) < msg_len_ff,
      "readout index beyond run length")
   `ASSERT_NEXT(a_run_end_to_cmd, (mode_ff == M_RD_LOAD) && run_end,
      (mode_ff == M_CMD) && rsp_valid_ff && rsp_ch.last,
      "text run did not end with final result")
   `ASSERT_IMPL(a_char_write_in_range, wr_en, char_cnt_ff < LW'(BUF_DEPTH),
      "buffer write beyond depth")

endmodule
